### rtl/thd_pkg.sv
// thd_pkg: shared types, codes and constants of the tap-and-hold detector.
// No dependencies; imported by every module of the block.
package thd_pkg;

    localparam int COORD_BITS_DEF = 12;
    localparam int TICK_W         = 16;
    localparam int RADIUS_W       = 12;
    localparam int RSQ_W          = 2 * RADIUS_W;
    localparam int CFG_ADDR_W     = 2;
    localparam int CFG_DATA_W     = 16;
    localparam int KIND_W         = 2;
    localparam int VERDICT_W      = 3;

    localparam logic [TICK_W-1:0]   ACT_RST    = 16'd500;
    localparam logic [TICK_W-1:0]   HOLD_RST   = 16'd1000;
    localparam logic [RADIUS_W-1:0] RADIUS_RST = 12'd16;
    localparam logic [RSQ_W-1:0]    RSQ_RST    = RSQ_W'(RADIUS_RST) * RSQ_W'(RADIUS_RST);

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS   = 2'd0,
        KIND_MOVE    = 2'd1,
        KIND_RELEASE = 2'd2,
        KIND_TICK    = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_WAIT = 2'd1,
        PH_HOLD = 2'd2
    } t_phase;

    typedef enum logic [VERDICT_W-1:0] {
        V_IGNORE  = 3'd0,
        V_MAYBE   = 3'd1,
        V_TRIGGER = 3'd2,
        V_FINISH  = 3'd3,
        V_CANCEL  = 3'd4
    } t_verdict;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_ACT    = 2'd0,
        CFG_HOLD   = 2'd1,
        CFG_RADIUS = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [TICK_W-1:0] act_ticks;
        logic [TICK_W-1:0] hold_ticks;
        logic [RSQ_W-1:0]  radius_sq;
    } t_cfg;

endpackage

### rtl/thd_cfg_regs.sv
// thd_cfg_regs: configuration registers; keeps the tap radius as its square.
// Depends on thd_pkg.
module thd_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [thd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [thd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output thd_pkg::t_cfg                  o_cfg
);
    import thd_pkg::*;

    logic [TICK_W-1:0] r_act_ticks;
    logic [TICK_W-1:0] r_hold_ticks;
    logic [RSQ_W-1:0]  r_radius_sq;
    logic [RSQ_W-1:0]  n_radius_sq;

    // square once at write time, keeps the multiplier off the event path
    assign n_radius_sq = RSQ_W'(i_cfg_wdata[RADIUS_W-1:0]) * RSQ_W'(i_cfg_wdata[RADIUS_W-1:0]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_act_ticks  <= ACT_RST;
            r_hold_ticks <= HOLD_RST;
            r_radius_sq  <= RSQ_RST;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_addr))
                CFG_ACT:    r_act_ticks  <= i_cfg_wdata;
                CFG_HOLD:   r_hold_ticks <= i_cfg_wdata;
                CFG_RADIUS: r_radius_sq  <= n_radius_sq;
                default: begin
                    // unmapped index: no effect
                end
            endcase
        end
    end

    assign o_cfg.act_ticks  = r_act_ticks;
    assign o_cfg.hold_ticks = r_hold_ticks;
    assign o_cfg.radius_sq  = r_radius_sq;

endmodule

### rtl/thd_engine.sv
// thd_engine: gesture state (phase, tick count, start point) and the
// per-word decision logic. Depends on thd_pkg.
module thd_engine #(
    parameter int COORD_BITS = thd_pkg::COORD_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_go,
    input  thd_pkg::t_kind        i_kind,
    input  logic                  i_prim,
    input  logic [COORD_BITS-1:0] i_x,
    input  logic [COORD_BITS-1:0] i_y,
    input  thd_pkg::t_cfg         i_cfg,
    output thd_pkg::t_verdict     o_verdict,
    output logic                  o_consumed,
    output logic [COORD_BITS-1:0] o_hot_x,
    output logic [COORD_BITS-1:0] o_hot_y
);
    import thd_pkg::*;

    localparam int SQ_W   = 2 * COORD_BITS;
    localparam int SUM_W  = SQ_W + 1;
    localparam int CMP_W  = (SUM_W > RSQ_W) ? SUM_W : RSQ_W;

    t_phase                r_phase, n_phase;
    logic [TICK_W-1:0]     r_tick_count, n_tick_count;
    logic [COORD_BITS-1:0] r_start_x, n_start_x;
    logic [COORD_BITS-1:0] r_start_y, n_start_y;

    logic                  busy;
    logic [COORD_BITS-1:0] dx_abs, dy_abs;
    logic [SQ_W-1:0]       dx_sq, dy_sq;
    logic [SUM_W-1:0]      dist_sq;
    logic                  beyond;
    logic [TICK_W-1:0]     tick_inc;
    logic [TICK_W-1:0]     limit;
    logic                  tick_hit;

    assign busy = (r_phase == PH_WAIT) || (r_phase == PH_HOLD);

    // squared distance from the start point
    assign dx_abs  = (i_x >= r_start_x) ? (i_x - r_start_x) : (r_start_x - i_x);
    assign dy_abs  = (i_y >= r_start_y) ? (i_y - r_start_y) : (r_start_y - i_y);
    assign dx_sq   = SQ_W'(dx_abs) * SQ_W'(dx_abs);
    assign dy_sq   = SQ_W'(dy_abs) * SQ_W'(dy_abs);
    assign dist_sq = SUM_W'(dx_sq) + SUM_W'(dy_sq);
    assign beyond  = CMP_W'(dist_sq) > CMP_W'(i_cfg.radius_sq);

    // tick counter, wraps at 16 bits; >= so a lowered limit fires at once
    assign tick_inc = r_tick_count + TICK_W'(1);
    assign limit    = (r_phase == PH_WAIT) ? i_cfg.act_ticks : i_cfg.hold_ticks;
    assign tick_hit = tick_inc >= limit;

    // next state
    always_comb begin
        n_phase      = r_phase;
        n_tick_count = r_tick_count;
        n_start_x    = r_start_x;
        n_start_y    = r_start_y;
        case (i_kind)
            KIND_PRESS: begin
                if (i_prim) begin
                    n_start_x    = i_x;
                    n_start_y    = i_y;
                    n_phase      = PH_WAIT;
                    n_tick_count = '0;
                end
            end
            KIND_MOVE: begin
                if (i_prim && busy && beyond) begin
                    n_phase      = PH_IDLE;
                    n_tick_count = '0;
                end
            end
            KIND_RELEASE: begin
                if (busy) begin
                    n_phase      = PH_IDLE;
                    n_tick_count = '0;
                end
            end
            KIND_TICK: begin
                if (busy) begin
                    if (tick_hit) begin
                        n_tick_count = '0;
                        n_phase      = (r_phase == PH_WAIT) ? PH_HOLD : PH_IDLE;
                    end else begin
                        n_tick_count = tick_inc;
                    end
                end
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
    end

    // outputs
    always_comb begin
        o_verdict  = V_IGNORE;
        o_consumed = 1'b0;
        case (i_kind)
            KIND_PRESS: begin
                if (i_prim) o_verdict = V_MAYBE;
            end
            KIND_MOVE: begin
                if (i_prim && busy) o_verdict = beyond ? V_CANCEL : V_MAYBE;
            end
            KIND_RELEASE: begin
                if (busy) o_verdict = V_CANCEL;
            end
            KIND_TICK: begin
                if (busy && tick_hit) begin
                    o_consumed = 1'b1;
                    o_verdict  = (r_phase == PH_WAIT) ? V_TRIGGER : V_FINISH;
                end
            end
            default: begin
                o_verdict = V_IGNORE;
            end
        endcase
    end

    // start point as it stands after this word
    assign o_hot_x = n_start_x;
    assign o_hot_y = n_start_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= PH_IDLE;
            r_tick_count <= '0;
            r_start_x    <= '0;
            r_start_y    <= '0;
        end else if (i_go) begin
            r_phase      <= n_phase;
            r_tick_count <= n_tick_count;
            r_start_x    <= n_start_x;
            r_start_y    <= n_start_y;
        end
    end

    a_cancel_to_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_verdict == V_CANCEL) |=> (r_phase == PH_IDLE && r_tick_count == '0))
        else $error("cancel did not return to idle");

    a_trigger_to_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_verdict == V_TRIGGER) |=> (r_phase == PH_HOLD && r_tick_count == '0))
        else $error("trigger did not open the hold period");

    a_consumed_on_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && o_consumed) |-> (i_kind == KIND_TICK &&
                                  (r_phase == PH_WAIT || r_phase == PH_HOLD)))
        else $error("consumed outside a busy tick");

    a_press_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_go && i_kind == KIND_PRESS && i_prim) |=>
            (r_phase == PH_WAIT && r_start_x == $past(i_x) && r_start_y == $past(i_y)))
        else $error("primary press did not restart the wait");

endmodule

### rtl/tap_and_hold_detector_core.sv
// tap_and_hold_detector_core: top level of the long-press gesture detector.
// Depends on thd_pkg, thd_cfg_regs and thd_engine.
//
//  channel   dir  handshake                     payload
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser: kind; tdata: primary_only, pos_x, pos_y
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser: verdict; tdata: consumed, hot_x, hot_y
//  cfg       in   i_cfg_we (no wait)            i_cfg_addr index, i_cfg_wdata value
//
//  One word per clock sustained while m_axis_tready stays high. Two registers: the input register, then
//  the gesture logic (squared distance, tick compare) into the result register.
//  Synchronous active-low reset clears phase, tick count, start point, valids
//  and loads the register defaults (500 / 1000 / radius 16).
//  A stalled result holds in the result register; the input register still
//  takes a word, and s_axis_tready drops only when both stages are full.
module tap_and_hold_detector_core #(
    parameter  int COORD_BITS = thd_pkg::COORD_BITS_DEF,
    localparam int PAY_W      = 1 + 2 * COORD_BITS,
    localparam int TD_W       = ((PAY_W + 7) / 8) * 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // slave side
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [TD_W-1:0]                s_axis_tdata,  // primary_only, pos_x, pos_y, pad
    input  logic [thd_pkg::KIND_W-1:0]     s_axis_tuser,  // kind
    // master side
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [TD_W-1:0]                m_axis_tdata,  // consumed, hot_x, hot_y, pad
    output logic [thd_pkg::VERDICT_W-1:0]  m_axis_tuser,  // verdict
    // configuration write port
    input  logic                           i_cfg_we,
    input  logic [thd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [thd_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import thd_pkg::*;

    localparam int PAD_W = TD_W - PAY_W;

    t_cfg                  cfg;

    // input register
    logic                  r_in_valid;
    t_kind                 r_kind;
    logic                  r_prim;
    logic [COORD_BITS-1:0] r_x;
    logic [COORD_BITS-1:0] r_y;

    // result register
    logic                  r_out_valid;
    t_verdict              r_verdict;
    logic                  r_consumed;
    logic [COORD_BITS-1:0] r_hot_x;
    logic [COORD_BITS-1:0] r_hot_y;

    t_verdict              eng_verdict;
    logic                  eng_consumed;
    logic [COORD_BITS-1:0] eng_hot_x;
    logic [COORD_BITS-1:0] eng_hot_y;

    logic                  advance;
    logic                  s_take;

    // word moves from input to result stage when the result slot is free
    assign advance       = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    thd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    thd_engine #(
        .COORD_BITS (COORD_BITS)
    ) u_engine (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_go       (advance),
        .i_kind     (r_kind),
        .i_prim     (r_prim),
        .i_x        (r_x),
        .i_y        (r_y),
        .i_cfg      (cfg),
        .o_verdict  (eng_verdict),
        .o_consumed (eng_consumed),
        .o_hot_x    (eng_hot_x),
        .o_hot_y    (eng_hot_y)
    );

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_take) begin
            r_kind <= t_kind'(s_axis_tuser);
            r_prim <= s_axis_tdata[0];
            r_x    <= s_axis_tdata[COORD_BITS:1];
            r_y    <= s_axis_tdata[2*COORD_BITS:COORD_BITS+1];
        end
    end

    // result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_verdict  <= eng_verdict;
            r_consumed <= eng_consumed;
            r_hot_x    <= eng_hot_x;
            r_hot_y    <= eng_hot_y;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_verdict;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, r_hot_y, r_hot_x, r_consumed};

endmodule

### verif/thd_checker.sv
`timescale 1ns / 100ps
// thd_checker: predicts every result word of the tap-and-hold detector and
// compares it field by field. Depends on thd_pkg; instantiated beside the DUT.
module thd_checker #(
    parameter int COORD_BITS = thd_pkg::COORD_BITS_DEF,
    parameter int TD_W       = 32
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_evt_valid,
    input  logic                           i_evt_ready,
    input  logic [TD_W-1:0]                i_evt_data,   // primary_only, pos_x, pos_y, pad
    input  logic [thd_pkg::KIND_W-1:0]     i_evt_user,   // kind
    input  logic                           i_res_valid,
    input  logic                           i_res_ready,
    input  logic [TD_W-1:0]                i_res_data,   // consumed, hot_x, hot_y, pad
    input  logic [thd_pkg::VERDICT_W-1:0]  i_res_user,   // verdict
    input  logic                           i_cfg_we,
    input  logic [thd_pkg::CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [thd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output int                             o_errors,
    output int                             o_pending
);
    import thd_pkg::*;

    typedef struct {
        t_verdict              verdict;
        logic                  consumed;
        logic [COORD_BITS-1:0] hot_x;
        logic [COORD_BITS-1:0] hot_y;
    } t_gesture_result;

    // shadow of the registers and the gesture state
    logic [TICK_W-1:0]     act_limit;
    logic [TICK_W-1:0]     hold_limit;
    logic [RADIUS_W-1:0]   radius;
    t_phase                gest_phase;
    logic [TICK_W-1:0]     tick_cnt;
    logic [COORD_BITS-1:0] anchor_x;
    logic [COORD_BITS-1:0] anchor_y;

    t_gesture_result awaited_q[$];

    initial begin
        o_errors  = 0;
        o_pending = 0;
    end

    task automatic log_failure(input string msg);
        o_errors++;
        if (o_errors <= 10) begin
            $display("%0t thd_checker: %s", $time, msg);
        end
    endtask

    // one event through the gesture state machine
    task automatic step_gesture(input t_kind kind, input logic prim,
                                input logic [COORD_BITS-1:0] x,
                                input logic [COORD_BITS-1:0] y,
                                output t_gesture_result r);
        logic              busy;
        logic [TICK_W-1:0] limit;
        longint            dx;
        longint            dy;
        busy       = (gest_phase == PH_WAIT) || (gest_phase == PH_HOLD);
        r.verdict  = V_IGNORE;
        r.consumed = 1'b0;
        case (kind)
            KIND_PRESS: begin
                if (prim) begin
                    anchor_x   = x;
                    anchor_y   = y;
                    gest_phase = PH_WAIT;
                    tick_cnt   = '0;
                    r.verdict  = V_MAYBE;
                end
            end
            KIND_MOVE: begin
                if (prim && busy) begin
                    dx = longint'(x) - longint'(anchor_x);
                    dy = longint'(y) - longint'(anchor_y);
                    // on the circle itself still counts as inside
                    if (dx * dx + dy * dy > longint'(radius) * longint'(radius)) begin
                        gest_phase = PH_IDLE;
                        tick_cnt   = '0;
                        r.verdict  = V_CANCEL;
                    end else begin
                        r.verdict = V_MAYBE;
                    end
                end
            end
            KIND_RELEASE: begin
                if (busy) begin
                    gest_phase = PH_IDLE;
                    tick_cnt   = '0;
                    r.verdict  = V_CANCEL;
                end
            end
            default: begin
                if (busy) begin
                    limit    = (gest_phase == PH_WAIT) ? act_limit : hold_limit;
                    tick_cnt = tick_cnt + 1'b1;
                    // >= so a zero or lowered limit fires on the next tick
                    if (tick_cnt >= limit) begin
                        r.consumed = 1'b1;
                        tick_cnt   = '0;
                        if (gest_phase == PH_WAIT) begin
                            gest_phase = PH_HOLD;
                            r.verdict  = V_TRIGGER;
                        end else begin
                            gest_phase = PH_IDLE;
                            r.verdict  = V_FINISH;
                        end
                    end
                end
            end
        endcase
        r.hot_x = anchor_x;
        r.hot_y = anchor_y;
    endtask

    always @(posedge i_clk) begin
        t_gesture_result want;
        if (!i_rst_n) begin
            act_limit  = ACT_RST;
            hold_limit = HOLD_RST;
            radius     = RADIUS_RST;
            gest_phase = PH_IDLE;
            tick_cnt   = '0;
            anchor_x   = '0;
            anchor_y   = '0;
            awaited_q.delete();
        end else begin
            if (i_res_valid && i_res_ready) begin
                if (awaited_q.size() == 0) begin
                    log_failure($sformatf("result word with nothing expected: verdict %0d",
                                          i_res_user));
                end else begin
                    want = awaited_q.pop_front();
                    if (i_res_user !== want.verdict || i_res_data[0] !== want.consumed ||
                        i_res_data[COORD_BITS:1] !== want.hot_x ||
                        i_res_data[2*COORD_BITS:COORD_BITS+1] !== want.hot_y) begin
                        log_failure($sformatf({"mismatch: exp verdict %0d consumed %0d ",
                            "hot (%0d,%0d), got verdict %0d consumed %0d hot (%0d,%0d)"},
                            want.verdict, want.consumed, want.hot_x, want.hot_y,
                            i_res_user, i_res_data[0], i_res_data[COORD_BITS:1],
                            i_res_data[2*COORD_BITS:COORD_BITS+1]));
                    end
                end
            end
            if (i_evt_valid && i_evt_ready) begin
                step_gesture(t_kind'(i_evt_user), i_evt_data[0],
                             i_evt_data[COORD_BITS:1],
                             i_evt_data[2*COORD_BITS:COORD_BITS+1], want);
                awaited_q.push_back(want);
            end
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    CFG_ACT:    act_limit  = i_cfg_wdata;
                    CFG_HOLD:   hold_limit = i_cfg_wdata;
                    CFG_RADIUS: radius     = i_cfg_wdata[RADIUS_W-1:0];
                    default:    ;
                endcase
            end
        end
        o_pending = awaited_q.size();
    end

endmodule

### verif/tb.sv
`timescale 1ns / 100ps
// tb: stimulus and verdict for tap_and_hold_detector_core.
// Depends on thd_pkg, the DUT and thd_checker, which does all the checking.
module tb;
    import thd_pkg::*;

    localparam int COORD_BITS     = COORD_BITS_DEF;
    localparam int TD_W           = ((1 + 2 * COORD_BITS + 7) / 8) * 8;
    localparam int RUN_LIMIT      = 200000;  // cycles
    localparam int N_PHASES       = 8;
    localparam int PHASE_WORDS    = 200;
    localparam int STALL_PCT      = 14;
    localparam int HOLDOFF_CYCLES = 80;
    localparam int MAX_STEPS      = 40;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;
    // index past the last register: writes there must be dropped
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 2'd3;

    logic                  i_clk;
    logic                  i_rst_n       = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [TD_W-1:0]       s_axis_tdata  = '0;        // primary_only, pos_x, pos_y, pad
    logic [KIND_W-1:0]     s_axis_tuser  = KIND_PRESS; // kind
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [TD_W-1:0]       m_axis_tdata;              // consumed, hot_x, hot_y, pad
    logic [VERDICT_W-1:0]  m_axis_tuser;              // verdict
    logic                  i_cfg_we      = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr    = CFG_ACT;
    logic [CFG_DATA_W-1:0] i_cfg_wdata   = '0;

    int errors;
    int pending;
    int cycle_cnt = 0;

    // stimulus controls shared with the receiver process
    bit no_gaps      = 1'b0;
    bit holdoff_req  = 1'b0;
    int holdoff_left = 0;

    // register values as last written, used only to shape the stimulus
    int cur_act  = 500;
    int cur_hold = 1000;
    int cur_rad  = 16;
    int words_sent;

    tap_and_hold_detector_core #(.COORD_BITS(COORD_BITS)) dut (.*);

    thd_checker #(.COORD_BITS(COORD_BITS), .TD_W(TD_W)) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_evt_valid (s_axis_tvalid),
        .i_evt_ready (s_axis_tready),
        .i_evt_data  (s_axis_tdata),
        .i_evt_user  (s_axis_tuser),
        .i_res_valid (m_axis_tvalid),
        .i_res_ready (m_axis_tready),
        .i_res_data  (m_axis_tdata),
        .i_res_user  (m_axis_tuser),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= RUN_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random back-pressure, a long hold-off on request so the
    // two pipeline stages fill and s_axis_tready drops, none when no_gaps.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (holdoff_left > 0) begin
            m_axis_tready <= 1'b0;
            holdoff_left--;
        end else if (holdoff_req) begin
            holdoff_req   = 1'b0;
            holdoff_left  = HOLDOFF_CYCLES;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= no_gaps || ($urandom_range(99) >= STALL_PCT);
        end
    end

    function automatic int clamp_coord(input int v);
        return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
    endfunction

    // Offer one event word and return at the edge that takes it. tvalid stays
    // high so back-to-back words need no extra assignment.
    task automatic send_event(input t_kind kind, input logic prim, input int x, input int y);
        if (!no_gaps && $urandom_range(99) < STALL_PCT) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= TD_W'({y[COORD_BITS-1:0], x[COORD_BITS-1:0], prim});
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    // Stop sending and wait until every expected result word is back.
    // Sampled at the falling edge, clear of the checker's update.
    task automatic wait_results();
        s_axis_tvalid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
    endtask

    // Write all registers plus the unused index; only called with the block drained.
    task automatic program_regs(input logic [15:0] act, input logic [15:0] hold,
                                input logic [15:0] rad);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= CFG_ACT;
        i_cfg_wdata <= act;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_HOLD;
        i_cfg_wdata <= hold;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_RADIUS;
        i_cfg_wdata <= rad;
        @(posedge i_clk);
        i_cfg_addr  <= CFG_UNUSED;
        i_cfg_wdata <= 16'($urandom);
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        cur_act  = int'(act);
        cur_hold = int'(hold);
        cur_rad  = int'(rad[RADIUS_W-1:0]);
    endtask

    // One gesture attempt: a press, then mostly ticks and moves around the start
    // point, sometimes a release, a re-press or a fully random word.
    task automatic run_gesture();
        int sx;
        int sy;
        int r;
        int steps;
        int pick;
        int span;
        int dx;
        int dy;
        sx    = $urandom_range(COORD_MAX);
        sy    = $urandom_range(COORD_MAX);
        r     = cur_rad;
        steps = ((cur_act + cur_hold > MAX_STEPS) ? MAX_STEPS : cur_act + cur_hold)
                + $urandom_range(0, 4);
        send_event(KIND_PRESS, $urandom_range(9) != 0, sx, sy);
        words_sent++;
        for (int i = 0; i < steps; i++) begin
            pick = $urandom_range(99);
            if (pick < 55) begin
                send_event(KIND_TICK, 1'($urandom), $urandom_range(COORD_MAX),
                           $urandom_range(COORD_MAX));
            end else if (pick < 85) begin
                if ($urandom_range(19) == 0) begin
                    dx = r;      // right on the circle
                    dy = 0;
                end else if ($urandom_range(9) == 0) begin
                    span = r + 1 + $urandom_range(64);
                    dx   = $urandom_range(1) ? span : -span;
                    dy   = $urandom_range(0, r);
                end else begin
                    span = r * 7 / 10;
                    dx   = $urandom_range(0, 2 * span) - span;
                    dy   = $urandom_range(0, 2 * span) - span;
                end
                send_event(KIND_MOVE, $urandom_range(9) != 0, clamp_coord(sx + dx),
                           clamp_coord(sy + dy));
            end else if (pick < 92) begin
                send_event(KIND_RELEASE, 1'($urandom), $urandom_range(COORD_MAX),
                           $urandom_range(COORD_MAX));
                words_sent++;
                break;
            end else if (pick < 97) begin
                // restart from a new point while busy
                sx = $urandom_range(COORD_MAX);
                sy = $urandom_range(COORD_MAX);
                send_event(KIND_PRESS, 1'b1, sx, sy);
            end else begin
                // noise word, not counted
                send_event(t_kind'($urandom_range(3)), 1'($urandom),
                           $urandom_range(COORD_MAX), $urandom_range(COORD_MAX));
                continue;
            end
            words_sent++;
        end
    endtask

    initial begin
        logic [15:0] act;
        logic [15:0] hold;
        logic [15:0] rad;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: idle cases at the reset defaults (500 / 1000 / radius 16)
        send_event(KIND_TICK, 1'b1, COORD_MAX, COORD_MAX);   // tick in idle
        send_event(KIND_MOVE, 1'b1, 10, 10);                 // move in idle
        send_event(KIND_RELEASE, 1'b1, 0, 0);                // release in idle
        send_event(KIND_PRESS, 1'b0, COORD_MAX, COORD_MAX);  // secondary button
        send_event(KIND_PRESS, 1'b1, 0, 0);
        send_event(KIND_MOVE, 1'b1, 16, 0);                  // exactly on radius
        send_event(KIND_MOVE, 1'b0, COORD_MAX, COORD_MAX);   // other buttons held
        send_event(KIND_MOVE, 1'b1, 0, 17);                  // leaves radius

        // short timers, radius written with upper bits set (masks to max)
        wait_results();
        program_regs(16'd2, 16'd2, 16'hFFFF);
        send_event(KIND_PRESS, 1'b1, COORD_MAX, COORD_MAX);
        send_event(KIND_MOVE, 1'b1, 0, 0);                   // corner to corner
        send_event(KIND_PRESS, 1'b1, COORD_MAX, 0);
        send_event(KIND_TICK, 1'b0, 0, 0);
        send_event(KIND_PRESS, 1'b1, 2048, 2048);            // press while busy
        send_event(KIND_TICK, 1'b1, 0, 0);
        send_event(KIND_TICK, 1'b1, 0, 0);                   // trigger
        send_event(KIND_MOVE, 1'b1, 2048, 2048);             // move while holding
        send_event(KIND_TICK, 1'b0, 0, 0);
        send_event(KIND_TICK, 1'b0, 0, 0);                   // finish
        send_event(KIND_PRESS, 1'b1, 100, 200);
        send_event(KIND_TICK, 1'b1, 0, 0);
        send_event(KIND_RELEASE, 1'b0, 0, 0);                // release mid-wait

        // zero activation, longest hold, zero radius
        wait_results();
        program_regs(16'd0, 16'hFFFF, 16'd0);
        send_event(KIND_PRESS, 1'b1, 5, 5);
        send_event(KIND_TICK, 1'b1, 0, 0);                   // fires at once
        send_event(KIND_MOVE, 1'b1, 5, 5);
        send_event(KIND_MOVE, 1'b1, 5, 6);

        // limits lowered while a wait is running
        wait_results();
        program_regs(16'hFFFF, 16'hFFFF, 16'd300);
        send_event(KIND_PRESS, 1'b1, 9, 9);
        send_event(KIND_TICK, 1'b1, 0, 0);
        send_event(KIND_TICK, 1'b1, 0, 0);
        wait_results();
        program_regs(16'd1, 16'd1, 16'd300);
        send_event(KIND_TICK, 1'b1, 0, 0);                   // trigger
        send_event(KIND_TICK, 1'b1, 0, 0);                   // finish

        // Random phases, each with its own register setting. Phase 4 holds off
        // the result side for a long stretch, phase 5 runs without any idling.
        for (int p = 0; p < N_PHASES; p++) begin
            act  = 16'($urandom_range(0, 8));
            hold = 16'($urandom_range(0, 8));
            rad  = {4'($urandom), 12'($urandom_range(0, 400))};
            case (p)
                0: begin
                    act  = 16'd1;
                    hold = 16'd1;
                    rad  = 16'd0;
                end
                1: rad  = 16'hFFFF;
                2: act  = 16'hFFFF;
                3: hold = 16'hFFFF;
                default: ;
            endcase
            wait_results();
            program_regs(act, hold, rad);
            no_gaps     = (p == 5);
            holdoff_req = (p == 4);
            words_sent  = 0;
            while (words_sent < PHASE_WORDS) begin
                run_gesture();
            end
        end

        wait_results();
        repeat (8) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
